### hw/rtl/tvtm_pkg.sv
// Shared types, constants and the quarter-wave sine table of the three-voice tone mixer.
package tvtm_pkg;

	// Datapath sizing
	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int COUNT_BITS      = 24;
	localparam int VOICES          = 3;

	// Fixed field widths
	localparam int TUNE_BITS      = 32;
	localparam int AMP_BITS       = 15;
	localparam int RUN_BITS       = 24;
	localparam int SINE_BITS      = 15;
	localparam int SAMPLE_BITS    = 16;
	localparam int VOICE_BITS     = 16;
	localparam int SUM_BITS       = 18;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int IN_DATA_BITS   = 8;

	localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
	localparam int CMP_BITS   = ((COUNT_BITS > RUN_BITS) ? COUNT_BITS : RUN_BITS) + 1;

	// Register indexes on the config port
	localparam logic [CFG_INDEX_BITS-1:0] REG_TUNING_1  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TUNING_2  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TUNING_3  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_LEN   = 3'd4;

	// Reset values of the registers
	localparam logic [TUNE_BITS-1:0] RST_TUNING_1  = 32'd42852281;
	localparam logic [TUNE_BITS-1:0] RST_TUNING_2  = 32'd26994989;
	localparam logic [TUNE_BITS-1:0] RST_TUNING_3  = 32'd32103176;
	localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE = 15'd32657;
	localparam logic [RUN_BITS-1:0]  RST_RUN_LEN   = 24'd44100;

	// Table generation constants
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned FULL_SCALE  = 64'd32767;

	typedef struct packed {
		logic [TUNE_BITS-1:0] tuning_1;
		logic [TUNE_BITS-1:0] tuning_2;
		logic [TUNE_BITS-1:0] tuning_3;
		logic [AMP_BITS-1:0]  amplitude;
		logic [RUN_BITS-1:0]  run_length;
	} cfg_t;

	// Table address of one voice plus its half-wave sign
	typedef struct packed {
		logic [TABLE_ADDR_BITS-1:0] idx;
		logic                       neg;
	} voice_addr_t;

	typedef logic [SINE_BITS-1:0] sine_table_t [TABLE_SIZE];

	// Quarter-wave table, entry k = 32767 * sin(pi/2 * (k + 1/2) / TABLE_SIZE),
	// Taylor series to x^13 in Q30, each term truncated, result rounded half up.
	function automatic sine_table_t build_sine_table();
		sine_table_t          t;
		longint unsigned      x;
		longint unsigned      term;
		longint unsigned      val;
		longint               sum;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			x = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * TABLE_SIZE);
			sum = longint'(x);
			term = x;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			val = (64'(sum) * FULL_SCALE + 64'(1 << 29)) >> 30;
			t[k] = SINE_BITS'(val);
		end
		return t;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

### hw/rtl/three_voice_tone_mixer.sv
// Top level of the three-voice tone mixer: config registers, pipeline and mix.
// Each input request is one sample tick and yields exactly one output sample.
// One request is taken per clock while s_tready is high. The sine ROM read, the
// amplitude multiply and the sum and saturate each end in a register, the first
// at the accepting edge. Stages advance independently, so input keeps flowing
// into empty stages while a finished sample waits on m_tready.
// Config writes are taken every cycle (cfg_ready is tied high). Tuning and run
// length writes apply to requests accepted after the write; an amplitude write
// also reaches requests already past the table read; write only while the pipe
// is empty.
module three_voice_tone_mixer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tvtm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [tvtm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// sample tick input
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [tvtm_pkg::IN_DATA_BITS-1:0]     s_tdata,  // [0] chord_on, [1] restart
	// sample output
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [tvtm_pkg::SAMPLE_BITS-1:0]      m_tdata,  // [15:0] sample
	output logic                                  m_tuser,  // [0] clipped
	output logic                                  m_tlast
);

	tvtm_pkg::cfg_t                                   cfg_q;
	tvtm_pkg::voice_addr_t [tvtm_pkg::VOICES-1:0]     addr;
	logic                                             accept;
	logic                                             last_now;
	logic                                             rdy2;
	logic                                             rdy3;
	logic                                             v_s1;
	logic                                             v_s2;
	logic                                             out_v_q;
	logic                                             chord_s1;
	logic                                             last_s1;
	logic [tvtm_pkg::VOICES-1:0]                      neg_s1;
	logic [tvtm_pkg::SINE_BITS-1:0]                   tab_s1 [tvtm_pkg::VOICES];
	logic                                             chord_s2;
	logic                                             last_s2;
	logic signed [tvtm_pkg::VOICE_BITS-1:0]           voice_s2 [tvtm_pkg::VOICES];
	logic signed [tvtm_pkg::SUM_BITS-1:0]             sum;
	logic [tvtm_pkg::SAMPLE_BITS-1:0]                 sat;
	logic                                             sat_clip;
	logic [tvtm_pkg::SAMPLE_BITS-1:0]                 sample_q;
	logic                                             clipped_q;
	logic                                             last_q;

	// config register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tuning_1   <= tvtm_pkg::RST_TUNING_1;
			cfg_q.tuning_2   <= tvtm_pkg::RST_TUNING_2;
			cfg_q.tuning_3   <= tvtm_pkg::RST_TUNING_3;
			cfg_q.amplitude  <= tvtm_pkg::RST_AMPLITUDE;
			cfg_q.run_length <= tvtm_pkg::RST_RUN_LEN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tvtm_pkg::REG_TUNING_1: begin
					cfg_q.tuning_1 <= cfg_data[tvtm_pkg::TUNE_BITS-1:0];
				end
				tvtm_pkg::REG_TUNING_2: begin
					cfg_q.tuning_2 <= cfg_data[tvtm_pkg::TUNE_BITS-1:0];
				end
				tvtm_pkg::REG_TUNING_3: begin
					cfg_q.tuning_3 <= cfg_data[tvtm_pkg::TUNE_BITS-1:0];
				end
				tvtm_pkg::REG_AMPLITUDE: begin
					cfg_q.amplitude <= cfg_data[tvtm_pkg::AMP_BITS-1:0];
				end
				tvtm_pkg::REG_RUN_LEN: begin
					cfg_q.run_length <= cfg_data[tvtm_pkg::RUN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// per-stage ready chain
	assign rdy3     = !out_v_q || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign s_tready = !v_s1 || rdy2;
	assign accept   = s_tvalid && s_tready;

	tvtm_phase_ctrl u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.restart (s_tdata[1]),
		.cfg     (cfg_q),
		.addr    (addr),
		.last    (last_now)
	);

	// stages 1 and 2: table read and amplitude scaling per voice; stage 1 request flags
	for (genvar v = 0; v < tvtm_pkg::VOICES; v++) begin : g_voice
		tvtm_sine_rom u_rom (
			.clk     (clk),
			.en      (accept),
			.addr    (addr[v].idx),
			.data_s1 (tab_s1[v])
		);

		tvtm_voice_scale u_scale (
			.clk       (clk),
			.en        (v_s1 && rdy2),
			.tab_s1    (tab_s1[v]),
			.neg_s1    (neg_s1[v]),
			.amplitude (cfg_q.amplitude),
			.voice_s2  (voice_s2[v])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chord_s1 <= s_tdata[0];
			last_s1  <= last_now;
			for (int v = 0; v < tvtm_pkg::VOICES; v++) begin
				neg_s1[v] <= addr[v].neg;
			end
		end
	end

	// stage 2 flags follow the scaled voices
	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			chord_s2 <= chord_s1;
			last_s2  <= last_s1;
		end
	end

	// stage 3: sum, saturate, silence
	always_comb begin
		sum = tvtm_pkg::SUM_BITS'(voice_s2[0]) + tvtm_pkg::SUM_BITS'(voice_s2[1]) +
			tvtm_pkg::SUM_BITS'(voice_s2[2]);
		if (sum > 18'sd32767) begin
			sat      = 16'h7fff;
			sat_clip = 1'b1;
		end else if (sum < -18'sd32768) begin
			sat      = 16'h8000;
			sat_clip = 1'b1;
		end else begin
			sat      = sum[tvtm_pkg::SAMPLE_BITS-1:0];
			sat_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			sample_q  <= chord_s2 ? sat : '0;
			clipped_q <= chord_s2 && sat_clip;
			last_q    <= last_s2;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				out_v_q <= v_s2;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = sample_q;
	assign m_tuser  = clipped_q;
	assign m_tlast  = last_q;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_s2 && out_v_q)
		else $error("input stalled with an empty stage");

	a_s2_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2)
		else $error("stage two request dropped under stall");

	a_clip_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && clipped_q |-> sample_q == 16'h7fff || sample_q == 16'h8000)
		else $error("clip flag without a saturated sample");

	a_out_loads_s2: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q && !v_s2 |=> !out_v_q)
		else $error("output became valid without a stage two request");

endmodule

### hw/rtl/tvtm_sine_rom.sv
// Quarter-wave sine ROM with registered read data.
module tvtm_sine_rom (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [tvtm_pkg::TABLE_ADDR_BITS-1:0]  addr,
	output logic [tvtm_pkg::SINE_BITS-1:0]        data_s1
);

	// registered table read
	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= tvtm_pkg::SINE_TABLE[addr];
		end
	end

endmodule

### hw/rtl/tvtm_phase_ctrl.sv
// Phase accumulators, run counter and table address generation.
module tvtm_phase_ctrl (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               accept,
	input  logic                                               restart,
	input  tvtm_pkg::cfg_t                                     cfg,
	output tvtm_pkg::voice_addr_t [tvtm_pkg::VOICES-1:0]       addr,
	output logic                                               last
);

	logic [tvtm_pkg::VOICES-1:0][tvtm_pkg::PHASE_BITS-1:0] phase_q;
	logic [tvtm_pkg::VOICES-1:0][tvtm_pkg::PHASE_BITS-1:0] phase_cur;
	logic [tvtm_pkg::VOICES-1:0][tvtm_pkg::PHASE_BITS-1:0] inc;
	logic [tvtm_pkg::COUNT_BITS-1:0]                       count_q;
	logic [tvtm_pkg::COUNT_BITS-1:0]                       count_cur;
	logic [tvtm_pkg::CMP_BITS-1:0]                         count_next;
	logic [tvtm_pkg::CMP_BITS-1:0]                         limit;
	logic [tvtm_pkg::TABLE_ADDR_BITS+1:0]                  top_bits [tvtm_pkg::VOICES];

	// tuning words taken modulo the phase width
	assign inc[0] = tvtm_pkg::PHASE_BITS'({{tvtm_pkg::PHASE_BITS{1'b0}}, cfg.tuning_1});
	assign inc[1] = tvtm_pkg::PHASE_BITS'({{tvtm_pkg::PHASE_BITS{1'b0}}, cfg.tuning_2});
	assign inc[2] = tvtm_pkg::PHASE_BITS'({{tvtm_pkg::PHASE_BITS{1'b0}}, cfg.tuning_3});

	// restart clears state ahead of this sample
	assign phase_cur = restart ? '0 : phase_q;
	assign count_cur = restart ? '0 : count_q;

	// end of run; a zero run length acts as one
	assign limit = (cfg.run_length == '0) ? tvtm_pkg::CMP_BITS'(1) :
		tvtm_pkg::CMP_BITS'(cfg.run_length);
	assign count_next = tvtm_pkg::CMP_BITS'(count_cur) + tvtm_pkg::CMP_BITS'(1);
	assign last = (count_next >= limit);

	// quadrant decode: mirror in odd quadrants, negate in the second half
	always_comb begin
		for (int v = 0; v < tvtm_pkg::VOICES; v++) begin
			top_bits[v] = phase_cur[v][tvtm_pkg::PHASE_BITS-1 -: tvtm_pkg::TABLE_ADDR_BITS+2];
			addr[v].neg = top_bits[v][tvtm_pkg::TABLE_ADDR_BITS+1];
			addr[v].idx = top_bits[v][tvtm_pkg::TABLE_ADDR_BITS] ?
				~top_bits[v][tvtm_pkg::TABLE_ADDR_BITS-1:0] :
				top_bits[v][tvtm_pkg::TABLE_ADDR_BITS-1:0];
		end
	end

	// accumulator and counter update per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q <= '0;
				count_q <= '0;
			end else begin
				for (int v = 0; v < tvtm_pkg::VOICES; v++) begin
					phase_q[v] <= phase_cur[v] + inc[v];
				end
				count_q <= count_next[tvtm_pkg::COUNT_BITS-1:0];
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> (count_q == '0) && (phase_q == '0))
		else $error("run end did not clear phases and counter");

endmodule

### hw/rtl/tvtm_voice_scale.sv
// Amplitude scaling of one voice with sign restore, registered.
module tvtm_voice_scale (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [tvtm_pkg::SINE_BITS-1:0]        tab_s1,
	input  logic                                  neg_s1,
	input  logic [tvtm_pkg::AMP_BITS-1:0]         amplitude,
	output logic signed [tvtm_pkg::VOICE_BITS-1:0] voice_s2
);

	localparam int PROD_BITS = tvtm_pkg::SINE_BITS + tvtm_pkg::AMP_BITS;

	logic [PROD_BITS-1:0]            prod;
	logic [tvtm_pkg::SINE_BITS-1:0]  mag;

	// round half up, then drop the Q0.15 fraction
	assign prod = PROD_BITS'(tab_s1) * PROD_BITS'(amplitude) + PROD_BITS'(16384);
	assign mag  = prod[PROD_BITS-1 -: tvtm_pkg::SINE_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			voice_s2 <= neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule
